[design/slist_pkg.sv]
`default_nettype none

package slist_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned FuncW   = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned FposW   = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned DefaultCapacity = 64;

  // Request codes
  typedef enum logic [FuncW-1:0] {
    FN_CLEAR  = 3'd0,
    FN_READ   = 3'd1,
    FN_FIND   = 3'd2,
    FN_INSERT = 3'd3,
    FN_DELETE = 3'd4,
    FN_WRITE  = 3'd5
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/slist_cell.sv]
`default_nettype none

// One list slot. Shifts from its neighbors on insert/delete and compares
// its entry against the broadcast value every cycle.
module slist_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IdxW = 7
) (
  input  wire logic                            clk_i,
  input  wire slist_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [IdxW-1:0]                 pos_i,
  input  wire logic [IdxW-1:0]                 count_i,
  input  wire logic [slist_pkg::ValueW-1:0]    left_i,
  input  wire logic [slist_pkg::ValueW-1:0]    right_i,
  output logic      [slist_pkg::ValueW-1:0]    entry_o,
  output logic                                 match_o,
  output logic                                 sel_o
);

  localparam logic [IdxW-1:0] IdxV = IdxW'(Idx);

  logic [slist_pkg::ValueW-1:0] entry_q, entry_d;

  // Next entry from command and position relative to this slot
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      slist_pkg::CMD_INSERT: begin
        if (IdxV == pos_i) begin
          entry_d = ctrl_i.value;
        end else if ((IdxV > pos_i) && (IdxV <= count_i)) begin
          entry_d = left_i;
        end
      end
      slist_pkg::CMD_DELETE: begin
        if ((IdxV >= pos_i) && ((IdxV + 1'b1) < count_i)) begin
          entry_d = right_i;
        end
      end
      slist_pkg::CMD_WRITE: begin
        if (IdxV == pos_i) begin
          entry_d = ctrl_i.value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Search hit only counts for live slots
  assign match_o = (entry_q == ctrl_i.value) && (IdxV < count_i);
  assign sel_o   = (IdxV == pos_i);
  assign entry_o = entry_q;

endmodule

`default_nettype wire

[design/sequential_list_engine_unit.sv]
// Ordered list of signed 32-bit values held in a row of cells, one slot
// per cell, packed from position 0.
// Input stream s_axis: one request per transfer (clear, read, find,
// insert, delete, overwrite). Output stream m_axis: exactly one result
// per request, in request order.
// Two register stages. The input transfer edge updates the cells
// (all shifts happen in parallel across the row) and registers the read
// data and per-cell match flags in the middle stage; once the output
// register is free or being taken, the middle stage picks the lowest
// matching slot and loads the output register, which drives m_axis_tvalid_o.
// Throughput: one request per cycle while m_axis_tready_i stays high.
// When the receiver stalls, the output register holds its result, the
// middle stage fills, and s_axis_tready_o drops until the output drains.
// Reset clears the entry count (the list is empty) and both pipeline
// stages; slot contents are not reset and only slots below the count
// are ever read.
`default_nettype none

module sequential_list_engine_unit #(
  parameter int unsigned CAPACITY = slist_pkg::DefaultCapacity
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // func [2:0], position [9:3], value [41:10], zero pad [47:42]
  input  wire logic [slist_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // read_value [31:0], found [32], found_position [38:33],
  // status [40:39], count [47:41]
  output logic      [slist_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CntW > slist_pkg::PosW) ? CntW : slist_pkg::PosW;
  localparam int unsigned EncW = $clog2(CAPACITY);
  localparam int unsigned VW   = slist_pkg::ValueW;

  // Input field unpack
  logic [slist_pkg::FuncW-1:0] in_func;
  logic [slist_pkg::PosW-1:0]  in_pos;
  logic [VW-1:0]               in_value;
  assign in_func  = s_axis_tdata_i[2:0];
  assign in_pos   = s_axis_tdata_i[9:3];
  assign in_value = s_axis_tdata_i[41:10];

  logic accept, s2_adv;
  logic s2_valid_q, out_valid_q;

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] pos_w, cnt_w;

  slist_pkg::cell_ctrl_t ctrl;
  slist_pkg::cmd_e       cmd;
  slist_pkg::status_e    status;
  logic [VW-1:0]         rd_value;

  logic [VW-1:0]       entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] sel;
  logic [VW-1:0]       sel_or;

  // Middle stage registers
  slist_pkg::func_e    s2_func_q;
  slist_pkg::status_e  s2_status_q;
  logic [VW-1:0]       s2_rd_q;
  logic [CAPACITY-1:0] s2_match_q;
  logic [CntW-1:0]     s2_count_q;

  logic [slist_pkg::OutDataW-1:0] out_data_q;

  // Handshake: the middle stage moves on when the output is free
  assign s2_adv          = s2_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s2_valid_q || s2_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_w = IdxW'(in_pos);
  assign cnt_w = IdxW'(count_q);

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = entry[i+1];
    end

    slist_cell #(
      .Idx  (i),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_w),
      .count_i (cnt_w),
      .left_i  (left_v),
      .right_i (right_v),
      .entry_o (entry[i]),
      .match_o (match[i]),
      .sel_o   (sel[i])
    );
  end

  // Read mux: OR of one-hot selected entries
  always_comb begin
    sel_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_or = sel_or | (sel[i] ? entry[i] : '0);
    end
  end

  // Request decode
  always_comb begin
    cmd      = slist_pkg::CMD_HOLD;
    status   = slist_pkg::ST_OK;
    rd_value = '0;
    count_d  = count_q;
    unique case (slist_pkg::func_e'(in_func))
      slist_pkg::FN_CLEAR: begin
        count_d = '0;
      end
      slist_pkg::FN_READ: begin
        if (pos_w < cnt_w) begin
          rd_value = sel_or;
        end else begin
          status = slist_pkg::ST_RANGE;
        end
      end
      slist_pkg::FN_FIND: begin
        status = slist_pkg::ST_OK;
      end
      slist_pkg::FN_INSERT: begin
        if (pos_w > cnt_w) begin
          status = slist_pkg::ST_RANGE;
        end else if (count_q == CntW'(CAPACITY)) begin
          status = slist_pkg::ST_FULL;
        end else begin
          cmd     = slist_pkg::CMD_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      slist_pkg::FN_DELETE: begin
        if (pos_w < cnt_w) begin
          cmd     = slist_pkg::CMD_DELETE;
          count_d = count_q - 1'b1;
        end else begin
          status = slist_pkg::ST_RANGE;
        end
      end
      slist_pkg::FN_WRITE: begin
        if (pos_w < cnt_w) begin
          cmd = slist_pkg::CMD_WRITE;
        end else begin
          status = slist_pkg::ST_RANGE;
        end
      end
      default: begin
        status = slist_pkg::ST_OK;
      end
    endcase
  end

  assign ctrl.cmd   = accept ? cmd : slist_pkg::CMD_HOLD;
  assign ctrl.value = in_value;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Middle stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_func_q   <= slist_pkg::func_e'(in_func);
      s2_status_q <= status;
      s2_rd_q     <= rd_value;
      s2_match_q  <= match;
      s2_count_q  <= count_d;
    end
  end

  // Lowest set match bit: isolate it, then encode
  logic [CAPACITY-1:0] hit_vec, hit_low;
  logic [EncW-1:0]     hit_idx;
  logic                hit_any;

  assign hit_vec = (s2_func_q == slist_pkg::FN_FIND) ? s2_match_q : '0;
  assign hit_low = hit_vec & (~hit_vec + 1'b1);
  assign hit_any = |hit_vec;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx = hit_idx | (hit_low[i] ? EncW'(i) : '0);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_data_q <= {slist_pkg::CountW'(s2_count_q),
                     s2_status_q,
                     slist_pkg::FposW'(hit_idx),
                     hit_any,
                     s2_rd_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_func == slist_pkg::FN_CLEAR) |=> count_q == '0)
    else $error("clear did not empty the list");

  a_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == slist_pkg::CMD_INSERT) |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[40:39] == slist_pkg::ST_OK)
    else $error("find hit with error status");

  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s2_valid_q && out_valid_q)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
